// ----- hdl/eie_pkg.sv -----
// Shared types and constants for the eight-bit ISA executor.
// Holds opcode and function codes, the execute result struct and the bus widths.
// Depends on nothing; eie_exec, the top level and the checker import it.
package eie_pkg;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   typedef enum logic [1:0] {
      FUNC_EXEC = 2'd0,
      FUNC_WREG = 2'd1,
      FUNC_WMEM = 2'd2,
      FUNC_RMEM = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_INC  = 4'd3,
      OP_AND  = 4'd4,
      OP_OR   = 4'd5,
      OP_XOR  = 4'd6,
      OP_NOT  = 4'd7,
      OP_SLLI = 4'd8,
      OP_SRLI = 4'd9,
      OP_LI   = 4'd10,
      OP_LD   = 4'd11,
      OP_ST   = 4'd12,
      OP_JMP  = 4'd13,
      OP_BEQZ = 4'd14,
      OP_HLT  = 4'd15
   } opcode_type;

   typedef struct packed {
      logic       reg_we;
      logic [3:0] dreg;
      logic [7:0] dvalue;
      logic       is_load;
      logic       is_read;
      logic       mem_re;
      logic       mem_we;
      logic [7:0] mem_addr;
      logic [7:0] mem_wdata;
      logic [7:0] next_pc;
      logic       halt;
   } exec_result_type;

endpackage

// ----- hdl/eie_ram.sv -----
// Generic synchronous RAM with one write port and one registered read port.
// Read-first on a same-address collision; read data holds while rd_en is low.
// Depends on nothing.
module eie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- hdl/eie_exec.sv -----
// Execute unit: decodes one word and forms register, memory, PC and halt effects.
// Purely combinational; operands arrive already forwarded. Uses eie_pkg.
module eie_exec (
   input  eie_pkg::func_type        func,
   input  logic [15:0]              iw,
   input  logic [3:0]               rsel,
   input  logic [7:0]               maddr,
   input  logic [7:0]               wval,
   input  logic [7:0]               opa,
   input  logic [7:0]               opb,
   input  logic                     dest_ok,
   input  logic                     sel_ok,
   input  logic [7:0]               pc,
   input  logic                     halted,
   output eie_pkg::exec_result_type res
);
   import eie_pkg::*;

   opcode_type  op;
   logic [3:0]  fa;
   logic [3:0]  fb;
   logic [3:0]  fc;
   logic [15:0] prod;
   logic [7:0]  alu;
   logic        has_res;
   logic        is_ld;
   logic [7:0]  ls_addr;
   logic [7:0]  pc_inc;

   assign op      = opcode_type'(iw[15:12]);
   assign fa      = iw[11:8];
   assign fb      = iw[7:4];
   assign fc      = iw[3:0];
   assign prod    = 16'(opa) * 16'(opb);
   assign ls_addr = opa + {{4{fc[3]}}, fc};
   assign pc_inc  = pc + 8'd2;
   assign is_ld   = (op == OP_LD);

   always_comb begin
      has_res = 1'b1;
      alu     = 8'd0;
      case (op)
         OP_ADD:  alu = opa + opb;
         OP_SUB:  alu = opa - opb;
         OP_MUL:  alu = prod[7:0];
         OP_INC:  alu = opa + 8'd1;
         OP_AND:  alu = opa & opb;
         OP_OR:   alu = opa | opb;
         OP_XOR:  alu = opa ^ opb;
         OP_NOT:  alu = ~opa;
         OP_SLLI: alu = opa << fc;
         OP_SRLI: alu = opa >> fc;
         OP_LI:   alu = {fb, fc};
         OP_LD:   alu = 8'd0;
         default: has_res = 1'b0;
      endcase
   end

   always_comb begin
      res         = '0;
      res.next_pc = pc;
      res.halt    = halted;
      case (func)
         FUNC_WREG: begin
            if (sel_ok) begin
               res.reg_we = 1'b1;
               res.dreg   = rsel;
               res.dvalue = wval;
            end
         end
         FUNC_WMEM: begin
            res.mem_we    = 1'b1;
            res.mem_addr  = maddr;
            res.mem_wdata = wval;
         end
         FUNC_RMEM: begin
            res.mem_re   = 1'b1;
            res.is_read  = 1'b1;
            res.mem_addr = maddr;
         end
         FUNC_EXEC: begin
            if (!halted) begin
               res.next_pc = pc_inc;
               case (op)
                  OP_LD: begin
                     res.mem_re   = 1'b1;
                     res.mem_addr = ls_addr;
                  end
                  OP_ST: begin
                     res.mem_we    = 1'b1;
                     res.mem_addr  = ls_addr;
                     res.mem_wdata = opb;
                  end
                  OP_JMP: begin
                     res.next_pc = pc_inc + {fa[2:0], fb, 1'b0};
                  end
                  OP_BEQZ: begin
                     if (opb == 8'd0) begin
                        res.next_pc = pc_inc + {fb[2:0], fc, 1'b0};
                     end
                  end
                  OP_HLT: begin
                     res.halt = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (has_res && dest_ok) begin
                  res.reg_we  = 1'b1;
                  res.dreg    = fa;
                  res.dvalue  = alu;
                  res.is_load = is_ld;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hdl/eight_bit_isa_executor_core.sv -----
// Top level of the eight-bit ISA executor: three-stage pipeline around RAMs.
// Instantiates eie_ram (register file twice, data memory once) and eie_exec.
// Uses eie_pkg for codes, the result struct and bus widths.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_tvalid/req_tready  tuser: func; tdata: instruction and access fields
//   rsp      out  rsp_tvalid/rsp_tready  tuser: register_written; tdata: result fields
//
// One word is accepted per cycle while the pipeline does not hold and no clearing pass runs.
// The register file is read in the accept cycle and the data memory in the execute cycle;
// the result is registered into s2 and presented on rsp; register writes are forwarded to later words.
// After reset a clearing pass steps through every data memory address and zeroes both memories with req_tready low.
// While a result waits and rsp_tready is low, the whole pipeline holds.
module eight_bit_isa_executor_core #(
   parameter int NUM_REGS  = 16,
   parameter int MEM_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // instruction_word[15:0], register_select[19:16], memory_address[27:20],
   // write_value[35:28], zero fill [39:36]
   input  logic [eie_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func[1:0]
   input  logic [eie_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // next_pc[7:0], halted[8], read_value[16:9], dest_register[20:17],
   // dest_value[28:21], zero fill [31:29]
   output logic [eie_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // register_written[0]
   output logic [eie_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import eie_pkg::*;

   localparam int RW = $clog2(NUM_REGS);
   localparam int MW = $clog2(MEM_DEPTH);

   function automatic logic [MW-1:0] mem_wrap(input logic [7:0] raw);
      logic [11:0] r;
      r = {4'd0, raw};
      for (int k = 3; k >= 0; k--) begin
         if (r >= (12'(MEM_DEPTH) << k)) begin
            r = r - (12'(MEM_DEPTH) << k);
         end
      end
      return r[MW-1:0];
   endfunction

   logic            adv;
   logic            accept;
   opcode_type      req_op;
   logic [3:0]      rd0_idx;
   logic [3:0]      rd1_idx;

   logic            clr_ff, clr_in;
   logic [MW-1:0]   clr_addr_ff, clr_addr_in;
   logic            rf_clr_we;

   logic            s1_valid_ff, s1_valid_in;
   func_type        s1_func_ff;
   logic [15:0]     s1_iw_ff;
   logic [3:0]      s1_rsel_ff;
   logic [7:0]      s1_maddr_ff;
   logic [7:0]      s1_wval_ff;
   opcode_type      s1_op;
   logic [3:0]      s1_idx0;
   logic [3:0]      s1_idx1;
   logic            s1_ok0;
   logic            s1_ok1;
   logic            dest_ok;
   logic            sel_ok;
   logic [7:0]      opa;
   logic [7:0]      opb;

   logic [7:0]      pc_ff, pc_in;
   logic            halted_ff, halted_in;

   logic            s2_valid_ff, s2_valid_in;
   logic [7:0]      s2_pc_ff;
   logic            s2_halt_ff;
   logic            s2_wr_ff;
   logic [3:0]      s2_dreg_ff;
   logic [7:0]      s2_value_ff;
   logic            s2_load_ff;
   logic            s2_read_ff;
   logic [7:0]      s2_fwd_value;

   logic            wb_valid_ff, wb_valid_in;
   logic [3:0]      wb_reg_ff;
   logic [7:0]      wb_value_ff;

   exec_result_type ex;
   logic [MW-1:0]   mem_idx;
   logic [7:0]      rf_q0;
   logic [7:0]      rf_q1;
   logic [7:0]      mem_q;
   logic            rf_we;
   logic [RW-1:0]   rf_waddr;
   logic [7:0]      rf_wdata;
   logic            dm_we;
   logic [MW-1:0]   dm_waddr;
   logic [7:0]      dm_wdata;
   logic            dm_re;
   logic [7:0]      read_value;

   assign adv        = !s2_valid_ff || rsp_tready;
   assign req_tready = adv && !clr_ff;
   assign accept     = req_tvalid && req_tready;

   assign req_op  = opcode_type'(req_tdata[15:12]);
   assign rd0_idx = req_tdata[7:4];
   assign rd1_idx = (req_op inside {OP_ST, OP_BEQZ}) ? req_tdata[11:8] : req_tdata[3:0];

   assign s1_op   = opcode_type'(s1_iw_ff[15:12]);
   assign s1_idx0 = s1_iw_ff[7:4];
   assign s1_idx1 = (s1_op inside {OP_ST, OP_BEQZ}) ? s1_iw_ff[11:8] : s1_iw_ff[3:0];
   assign s1_ok0  = {1'b0, s1_idx0} < 5'(NUM_REGS);
   assign s1_ok1  = {1'b0, s1_idx1} < 5'(NUM_REGS);
   assign dest_ok = {1'b0, s1_iw_ff[11:8]} < 5'(NUM_REGS);
   assign sel_ok  = {1'b0, s1_rsel_ff} < 5'(NUM_REGS);

   assign s2_fwd_value = s2_load_ff ? mem_q : s2_value_ff;

   always_comb begin
      if (!s1_ok0) begin
         opa = 8'd0;
      end else if (s2_valid_ff && s2_wr_ff && s2_dreg_ff == s1_idx0) begin
         opa = s2_fwd_value;
      end else if (wb_valid_ff && wb_reg_ff == s1_idx0) begin
         opa = wb_value_ff;
      end else begin
         opa = rf_q0;
      end
   end

   always_comb begin
      if (!s1_ok1) begin
         opb = 8'd0;
      end else if (s2_valid_ff && s2_wr_ff && s2_dreg_ff == s1_idx1) begin
         opb = s2_fwd_value;
      end else if (wb_valid_ff && wb_reg_ff == s1_idx1) begin
         opb = wb_value_ff;
      end else begin
         opb = rf_q1;
      end
   end

   eie_exec u_exec (
      .func    (s1_func_ff),
      .iw      (s1_iw_ff),
      .rsel    (s1_rsel_ff),
      .maddr   (s1_maddr_ff),
      .wval    (s1_wval_ff),
      .opa     (opa),
      .opb     (opb),
      .dest_ok (dest_ok),
      .sel_ok  (sel_ok),
      .pc      (pc_ff),
      .halted  (halted_ff),
      .res     (ex)
   );

   assign mem_idx   = mem_wrap(ex.mem_addr);
   assign rf_clr_we = clr_ff && ({1'b0, clr_addr_ff} < (MW + 1)'(NUM_REGS));

   assign rf_we    = clr_ff ? rf_clr_we : (adv && s2_valid_ff && s2_wr_ff);
   assign rf_waddr = clr_ff ? clr_addr_ff[RW-1:0] : s2_dreg_ff[RW-1:0];
   assign rf_wdata = clr_ff ? 8'd0 : s2_fwd_value;

   assign dm_we    = clr_ff || (adv && s1_valid_ff && ex.mem_we);
   assign dm_waddr = clr_ff ? clr_addr_ff : mem_idx;
   assign dm_wdata = clr_ff ? 8'd0 : ex.mem_wdata;
   assign dm_re    = adv && s1_valid_ff && ex.mem_re;

   eie_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf0 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (adv),
      .rd_addr (rd0_idx[RW-1:0]),
      .rd_data (rf_q0)
   );

   eie_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf1 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (adv),
      .rd_addr (rd1_idx[RW-1:0]),
      .rd_data (rf_q1)
   );

   eie_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_en   (dm_re),
      .rd_addr (mem_idx),
      .rd_data (mem_q)
   );

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == MW'(MEM_DEPTH - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + MW'(1);
         end
      end
      s1_valid_in = adv ? accept : s1_valid_ff;
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
      wb_valid_in = adv ? (s2_valid_ff && s2_wr_ff) : wb_valid_ff;
      pc_in       = (adv && s1_valid_ff) ? ex.next_pc : pc_ff;
      halted_in   = (adv && s1_valid_ff) ? ex.halt : halted_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
         pc_ff       <= 8'd0;
         halted_ff   <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         wb_valid_ff <= wb_valid_in;
         pc_ff       <= pc_in;
         halted_ff   <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff  <= func_type'(req_tuser[1:0]);
         s1_iw_ff    <= req_tdata[15:0];
         s1_rsel_ff  <= req_tdata[19:16];
         s1_maddr_ff <= req_tdata[27:20];
         s1_wval_ff  <= req_tdata[35:28];
      end
      if (adv) begin
         s2_pc_ff    <= ex.next_pc;
         s2_halt_ff  <= ex.halt;
         s2_wr_ff    <= ex.reg_we;
         s2_dreg_ff  <= ex.dreg;
         s2_value_ff <= ex.dvalue;
         s2_load_ff  <= ex.is_load;
         s2_read_ff  <= ex.is_read;
         wb_reg_ff   <= s2_dreg_ff;
         wb_value_ff <= s2_fwd_value;
      end
   end

   assign read_value = s2_read_ff ? mem_q : 8'd0;
   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {3'd0, s2_fwd_value, s2_dreg_ff, read_value, s2_halt_ff, s2_pc_ff};
   assign rsp_tuser  = s2_wr_ff;

endmodule

// ----- hdl/eie_checker.sv -----
// Port-level checker for the eight-bit ISA executor, bound to the top level.
// Watches only the top-level ports. Uses eie_pkg for bus widths.
module eie_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [eie_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [eie_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [eie_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [eie_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import eie_pkg::*;

   logic seen_halt_ff, seen_halt_in;

   assign seen_halt_in = seen_halt_ff || (rsp_tvalid && rsp_tready && rsp_tdata[8]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else begin
         seen_halt_ff <= seen_halt_in;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word presented right after reset");

   a_clear_blocks_input: assert property (@(posedge clock) $fell(reset) |-> !req_tready)
      else $error("input taken before the memories were cleared");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && seen_halt_ff) |-> rsp_tdata[8])
      else $error("halted flag dropped without reset");

   a_no_write_zero_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[28:17] == 12'd0))
      else $error("destination fields set on a word that wrote no register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind eight_bit_isa_executor_core eie_checker u_checker (.*);
